FILE: hdl/fsnr_pkg.sv
// ----------------------------------------------------------------------------
// fsnr_pkg: shared types and constants
// Table geometry, register indexes, the map entry layout, the command and
// status bundles between controller and datapath, and the probe hash.
// ----------------------------------------------------------------------------
`default_nettype none

package fsnr_pkg;

  localparam int unsigned NUM_NODES   = 4;
  localparam int unsigned TABLE_DEPTH = 1024;

  localparam int unsigned IDX_W     = $clog2(TABLE_DEPTH);
  localparam int unsigned NODE_W    = 6;
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned CFG_IDX_W = 2;

  // node id handed to the first new address (count 1)
  localparam logic [NODE_W-1:0] NODE_FIRST = NODE_W'(1 % NUM_NODES);
  localparam logic [NODE_W-1:0] NODE_LAST  = NODE_W'(NUM_NODES - 1);
  localparam logic [IDX_W-1:0]  IDX_LAST   = IDX_W'(TABLE_DEPTH - 1);

  localparam logic [ADDR_W-1:0] BASE_IP_RST     = 32'h0000_0000;
  localparam logic [ADDR_W-1:0] NODE_STRIDE_RST = 32'h0001_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_IP     = 2'd0,
    REG_NODE_STRIDE = 2'd1
  } reg_idx_e;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] key;
    logic [NODE_W-1:0] node;
    logic [ADDR_W-1:0] addr;
  } entry_t;

  typedef struct packed {
    logic clr;       // write an empty entry at the probe pointer and advance
    logic load;      // latch request address, point probe at its hash
    logic rd;        // read entry at probe pointer
    logic step;      // advance probe pointer and probe count
    logic mul;       // register node * stride
    logic ins;       // write new entry, load new-address result
    logic out_hit;   // load result from read entry
    logic out_full;  // load table-full result
  } cmd_t;

  typedef struct packed {
    logic last_addr;    // probe pointer at last table entry
    logic hit;          // read entry is valid and holds the key
    logic empty;        // read entry is free
    logic probes_done;  // every entry has been probed
    logic out_free;     // result register can take a new result
  } sts_t;

  // Fold the 32-bit key into a table index; one compare-subtract for
  // depths that are not a power of two.
  function automatic logic [IDX_W-1:0] hash_idx(input logic [ADDR_W-1:0] key);
    logic [IDX_W-1:0] h;
    h = '0;
    for (int i = 0; i < ADDR_W; i++) begin
      h[i % IDX_W] = h[i % IDX_W] ^ key[i];
    end
    if ({1'b0, h} > (IDX_W+1)'(TABLE_DEPTH - 1)) begin
      h = IDX_W'({1'b0, h} - (IDX_W+1)'(TABLE_DEPTH));
    end
    return h;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/fsnr_ctrl.sv
// ----------------------------------------------------------------------------
// fsnr_ctrl: sequencing controller
// Clears the table after reset, then walks each request through hash probes,
// insert, hit or table-full, and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fsnr_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire fsnr_pkg::sts_t  sts_i,
  output fsnr_pkg::cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_MUL,
    ST_INS,
    ST_HIT_OUT,
    ST_FULL_OUT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.last_addr) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_CMP;
      end
      ST_CMP: begin
        if (sts_i.hit) begin
          state_d = ST_HIT_OUT;
        end else if (sts_i.empty) begin
          state_d = ST_MUL;
        end else if (sts_i.probes_done) begin
          state_d = ST_FULL_OUT;
        end else begin
          cmd_o.step = 1'b1;
          state_d    = ST_READ;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_INS;
      end
      ST_INS: begin
        if (sts_i.out_free) begin
          cmd_o.ins = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      ST_HIT_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_hit = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      ST_FULL_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_full = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/fsnr_dp.sv
// ----------------------------------------------------------------------------
// fsnr_dp: map datapath
// Open-addressed map memory with linear probing, node/offset counters,
// address arithmetic, configuration registers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fsnr_dp (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire fsnr_pkg::cmd_t                   cmd_i,
  output fsnr_pkg::sts_t                        sts_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [fsnr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [fsnr_pkg::ADDR_W-1:0]      cfg_data_i,
  input  wire logic [fsnr_pkg::ADDR_W-1:0]      ip_addr_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [fsnr_pkg::NODE_W-1:0]           node_id_o,
  output logic [fsnr_pkg::ADDR_W-1:0]           mapped_addr_o,
  output logic                                  was_new_o,
  output logic                                  table_full_o
);

  fsnr_pkg::entry_t mem [fsnr_pkg::TABLE_DEPTH];
  fsnr_pkg::entry_t rd_q;
  fsnr_pkg::entry_t wr_entry;
  logic             mem_we;

  logic [fsnr_pkg::ADDR_W-1:0] base_ip_q, node_stride_q;
  logic [fsnr_pkg::ADDR_W-1:0] key_q;
  logic [fsnr_pkg::IDX_W-1:0]  probe_q, probe_d;
  logic [fsnr_pkg::IDX_W-1:0]  probe_cnt_q;
  logic [fsnr_pkg::NODE_W-1:0] node_next_q;
  logic [fsnr_pkg::IDX_W-1:0]  quot_q;
  logic [fsnr_pkg::ADDR_W-1:0] prod_q;
  logic [fsnr_pkg::ADDR_W-1:0] new_addr;
  logic                        out_valid_q, out_valid_d;
  logic                        out_load;

  assign probe_d = (probe_q == fsnr_pkg::IDX_LAST) ? '0 : probe_q + 1'b1;

  assign new_addr = base_ip_q + prod_q + fsnr_pkg::ADDR_W'(quot_q);

  assign mem_we = cmd_i.clr | cmd_i.ins;

  always_comb begin
    wr_entry = '0;
    if (cmd_i.ins) begin
      wr_entry.valid = 1'b1;
      wr_entry.key   = key_q;
      wr_entry.node  = node_next_q;
      wr_entry.addr  = new_addr;
    end
  end

  // map memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[probe_q] <= wr_entry;
    end
    if (cmd_i.rd) begin
      rd_q <= mem[probe_q];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_ip_q     <= fsnr_pkg::BASE_IP_RST;
      node_stride_q <= fsnr_pkg::NODE_STRIDE_RST;
      probe_q       <= '0;
      probe_cnt_q   <= '0;
      node_next_q   <= fsnr_pkg::NODE_FIRST;
      quot_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          fsnr_pkg::REG_BASE_IP:     base_ip_q     <= cfg_data_i;
          fsnr_pkg::REG_NODE_STRIDE: node_stride_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        probe_q     <= fsnr_pkg::hash_idx(ip_addr_i);
        probe_cnt_q <= '0;
      end else if (cmd_i.clr || cmd_i.step) begin
        probe_q     <= probe_d;
        probe_cnt_q <= probe_cnt_q + 1'b1;
      end
      if (cmd_i.ins) begin
        // count c gets node c mod N and offset (c-1)/N
        node_next_q <= (node_next_q == fsnr_pkg::NODE_LAST) ? '0 : node_next_q + 1'b1;
        quot_q      <= quot_q + fsnr_pkg::IDX_W'(node_next_q == '0);
      end
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q <= ip_addr_i;
    end
    if (cmd_i.mul) begin
      prod_q <= fsnr_pkg::ADDR_W'(node_next_q * node_stride_q);
    end
    if (cmd_i.ins) begin
      node_id_o     <= node_next_q;
      mapped_addr_o <= new_addr;
      was_new_o     <= 1'b1;
      table_full_o  <= 1'b0;
    end else if (cmd_i.out_hit) begin
      node_id_o     <= rd_q.node;
      mapped_addr_o <= rd_q.addr;
      was_new_o     <= 1'b0;
      table_full_o  <= 1'b0;
    end else if (cmd_i.out_full) begin
      node_id_o     <= '0;
      mapped_addr_o <= '0;
      was_new_o     <= 1'b0;
      table_full_o  <= 1'b1;
    end
  end

  assign out_load = cmd_i.ins | cmd_i.out_hit | cmd_i.out_full;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  assign sts_o.last_addr   = (probe_q == fsnr_pkg::IDX_LAST);
  assign sts_o.hit         = rd_q.valid && (rd_q.key == key_q);
  assign sts_o.empty       = !rd_q.valid;
  assign sts_o.probes_done = (probe_cnt_q == fsnr_pkg::IDX_LAST);
  assign sts_o.out_free    = !out_valid_q || !out_stall_i;

endmodule

`default_nettype wire

FILE: hdl/first_seen_ip_to_node_remap.sv
// Sequence: each hash probe is a read then a compare; a hit then loads the
// result register, while a new address first registers node * stride and is
// then inserted. One request is in flight at a time; a stalled result holds
// off the insert or result load.
// Reset: clears control state, then a clearing pass over all TABLE_DEPTH (1024)
// entries empties the map; no request is taken during it, config writes are.
// ----------------------------------------------------------------------------
// first_seen_ip_to_node_remap: first-seen IPv4 address remapper
// Looks each address up in a hashed map; new addresses are assigned nodes
// round robin and a per-node address, stored, and flagged as new.
// ----------------------------------------------------------------------------
`default_nettype none

module first_seen_ip_to_node_remap (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // configuration write port
  input  wire logic                             cfg_we_i,
  input  wire logic [fsnr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [fsnr_pkg::ADDR_W-1:0]      cfg_data_i,
  // request channel
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [fsnr_pkg::ADDR_W-1:0]      ip_addr_i,
  // result channel
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [fsnr_pkg::NODE_W-1:0]           node_id_o,
  output logic [fsnr_pkg::ADDR_W-1:0]           mapped_addr_o,
  output logic                                  was_new_o,
  output logic                                  table_full_o
);

  // The controller sequences; the datapath owns the map memory, the
  // node/offset counters and the result register. The result register lets
  // a new request be taken while the previous result still waits.
  fsnr_pkg::cmd_t cmd;
  fsnr_pkg::sts_t sts;

  fsnr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Probing is linear from the hash of the address. Entries are never
  // removed, so the first free entry ends a miss; a full table is
  // recognized after every entry has been probed without a match.
  fsnr_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .ip_addr_i     (ip_addr_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .node_id_o     (node_id_o),
    .mapped_addr_o (mapped_addr_o),
    .was_new_o     (was_new_o),
    .table_full_o  (table_full_o)
  );

endmodule

`default_nettype wire

FILE: hdl/fsnr_checker.sv
// ----------------------------------------------------------------------------
// fsnr_checker: port-level checks
// Watches the request and result channels of the remapper.
// ----------------------------------------------------------------------------
`default_nettype none

module fsnr_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_valid_i,
  input wire logic                           in_stall_o,
  input wire logic                           out_valid_o,
  input wire logic                           out_stall_i,
  input wire logic [fsnr_pkg::NODE_W-1:0]    node_id_o,
  input wire logic [fsnr_pkg::ADDR_W-1:0]    mapped_addr_o,
  input wire logic                           was_new_o,
  input wire logic                           table_full_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(node_id_o)
      && $stable(mapped_addr_o) && $stable(was_new_o) && $stable(table_full_o))
    else $error("stalled result changed");

  // one request in flight: stall rises right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while another is in flight");

  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && table_full_o |-> !was_new_o && node_id_o == '0
      && mapped_addr_o == '0)
    else $error("table-full result carries data");

  a_node_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> node_id_o < fsnr_pkg::NODE_W'(fsnr_pkg::NUM_NODES))
    else $error("node id out of range");

endmodule

bind first_seen_ip_to_node_remap fsnr_checker u_fsnr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .node_id_o     (node_id_o),
  .mapped_addr_o (mapped_addr_o),
  .was_new_o     (was_new_o),
  .table_full_o  (table_full_o)
);

`default_nettype wire

FILE: test/tb_first_seen_ip_to_node_remap.sv
// ----------------------------------------------------------------------------
// tb_first_seen_ip_to_node_remap: self-checking bench for the address remapper
// Feeds IPv4 address requests through the valid/stall channel, keeps a private
// map of first-seen addresses to predict node, remapped address and flags, and
// compares every result in order. Covers several register settings, hash
// collisions, filling the map to the table-full state, and random back-pressure.
// ----------------------------------------------------------------------------

module tb_first_seen_ip_to_node_remap;

  // Spare register indexes: writes there must leave both registers untouched.
  localparam logic [fsnr_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [fsnr_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  localparam int unsigned CALM_ITEMS    = 150;   // tail of the run without idling
  localparam int unsigned HOLD_MARK_A   = 300;   // requests sent before first hold-off
  localparam int unsigned HOLD_MARK_B   = 1500;  // ... and before the second
  localparam int unsigned HOLD_LEN      = 300;   // cycles the receiver holds off
  localparam int unsigned SETTLE_CYCLES = 2200;  // longer than a full-table miss
  localparam int unsigned MAX_ERR_LINES = 100;

  typedef enum logic [1:0] {
    STEP_REQ,    // offer one address request
    STEP_CFG,    // register write, issued only once the block is idle
    STEP_DRAIN   // sender pauses until every result is back
  } step_kind_e;

  typedef struct packed {
    step_kind_e                     kind;
    logic [fsnr_pkg::ADDR_W-1:0]    ip;
    logic [fsnr_pkg::CFG_IDX_W-1:0] idx;
    logic [fsnr_pkg::ADDR_W-1:0]    data;
  } step_t;

  typedef struct packed {
    logic [fsnr_pkg::NODE_W-1:0] node;
    logic [fsnr_pkg::ADDR_W-1:0] addr;
    logic                        is_new;
    logic                        full;
  } remap_res_t;

  // --------------------------------------------------------------------------
  // DUT signals; every input has a known value from time zero
  // --------------------------------------------------------------------------
  logic                           clk_i    = 1'b0;
  logic                           rst_ni   = 1'b0;
  logic                           cfg_we   = 1'b0;
  logic [fsnr_pkg::CFG_IDX_W-1:0] cfg_idx  = '0;
  logic [fsnr_pkg::ADDR_W-1:0]    cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic [fsnr_pkg::ADDR_W-1:0]    ip_addr  = '0;
  logic                           out_stall = 1'b0;
  logic                           in_stall;
  logic                           out_valid;
  logic [fsnr_pkg::NODE_W-1:0]    node_id;
  logic [fsnr_pkg::ADDR_W-1:0]    mapped_addr;
  logic                           was_new;
  logic                           table_full;

  first_seen_ip_to_node_remap u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .ip_addr_i    (ip_addr),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .node_id_o    (node_id),
    .mapped_addr_o(mapped_addr),
    .was_new_o    (was_new),
    .table_full_o (table_full)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Prediction state: own copy of the registers and of the first-seen map
  // --------------------------------------------------------------------------
  logic [fsnr_pkg::ADDR_W-1:0] pred_base   = fsnr_pkg::BASE_IP_RST;
  logic [fsnr_pkg::ADDR_W-1:0] pred_stride = fsnr_pkg::NODE_STRIDE_RST;
  remap_res_t                  remap_tbl [logic [fsnr_pkg::ADDR_W-1:0]];
  int unsigned                 n_unique;

  step_t       req_backlog [$];  // stimulus not yet issued
  remap_res_t  exp_remaps  [$];  // predicted results, oldest first

  int unsigned n_total;          // requests in the whole run
  int unsigned n_sent;           // requests accepted (driver, NBA)
  int unsigned n_done;           // results accepted (monitor, NBA)
  int unsigned n_errors;
  int unsigned n_new_seen, n_hit_seen, n_full_seen, n_cfg_writes, n_held;
  logic        calm;

  // sender / receiver idling state, each owned by one process
  int unsigned send_gap, send_mode_left, rcv_gap, rcv_mode_left;
  int unsigned hold_left, holds_done;
  logic        send_noisy, rcv_noisy;

  assign calm = (n_sent + CALM_ITEMS >= n_total);

  task automatic flag_error(input string what);
    n_errors++;
    if (n_errors <= MAX_ERR_LINES) $display("ERROR @%0t: %s", $time, what);
  endtask

  // Hit returns the stored pair; a miss takes the next count c, node c mod N,
  // address base + node*stride + (c-1)/N (mod 2^32); a miss on a full map
  // stores nothing and returns only the full flag.
  function automatic remap_res_t remap_lookup(input logic [fsnr_pkg::ADDR_W-1:0] ip);
    remap_res_t  r;
    int unsigned cnt;
    r = '0;
    if (remap_tbl.exists(ip)) begin
      r = remap_tbl[ip];
    end else if (n_unique >= fsnr_pkg::TABLE_DEPTH) begin
      r.full = 1'b1;
    end else begin
      n_unique++;
      cnt    = n_unique;
      r.node = fsnr_pkg::NODE_W'(cnt % fsnr_pkg::NUM_NODES);
      r.addr = pred_base + fsnr_pkg::ADDR_W'(r.node) * pred_stride
             + fsnr_pkg::ADDR_W'((cnt - 1) / fsnr_pkg::NUM_NODES);
      remap_tbl[ip] = r;
      r.is_new = 1'b1;
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offers requests from the backlog, issues register writes when idle
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : drive_requests
    logic                           nxt_valid;
    logic [fsnr_pkg::ADDR_W-1:0]    nxt_ip;
    logic                           nxt_we;
    logic [fsnr_pkg::CFG_IDX_W-1:0] nxt_idx;
    logic [fsnr_pkg::ADDR_W-1:0]    nxt_data;
    step_t                          head;
    nxt_valid = in_valid;
    nxt_ip    = ip_addr;
    nxt_we    = 1'b0;
    nxt_idx   = cfg_idx;
    nxt_data  = cfg_data;
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        exp_remaps.push_back(remap_lookup(ip_addr));
        n_sent    <= n_sent + 1;
        nxt_valid = 1'b0;
      end
      // alternate between bursty and quiet stretches
      if (send_mode_left == 0) begin
        send_noisy     = ($urandom_range(0, 2) != 0);
        send_mode_left = $urandom_range(50, 300);
      end else begin
        send_mode_left--;
      end
      if (!nxt_valid && req_backlog.size() != 0) begin
        head = req_backlog[0];
        case (head.kind)
          STEP_REQ: begin
            if (send_gap != 0) begin
              send_gap--;
            end else if (send_noisy && !calm && $urandom_range(0, 5) == 0) begin
              send_gap = $urandom_range(0, 12);  // random idle gap before the next offer
            end else begin
              nxt_valid = 1'b1;
              nxt_ip    = head.ip;
              void'(req_backlog.pop_front());
            end
          end
          STEP_CFG: begin
            // idle: nothing offered at this edge and every result returned
            if (!in_valid && n_sent == n_done) begin
              nxt_we   = 1'b1;
              nxt_idx  = head.idx;
              nxt_data = head.data;
              if (head.idx == fsnr_pkg::REG_BASE_IP) pred_base = head.data;
              else if (head.idx == fsnr_pkg::REG_NODE_STRIDE) pred_stride = head.data;
              n_cfg_writes++;
              void'(req_backlog.pop_front());
            end
          end
          default: begin
            if (!in_valid && n_sent == n_done) void'(req_backlog.pop_front());
          end
        endcase
      end
    end
    in_valid <= nxt_valid;
    ip_addr  <= nxt_ip;
    cfg_we   <= nxt_we;
    cfg_idx  <= nxt_idx;
    cfg_data <= nxt_data;
  end

  // --------------------------------------------------------------------------
  // Receiver stall: random bursts plus two long hold-offs so the block backs
  // up and stalls its request side
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : stall_results
    logic nxt_stall;
    nxt_stall = 1'b0;
    if (rst_ni) begin
      if (rcv_mode_left == 0) begin
        rcv_noisy     = ($urandom_range(0, 2) != 0);
        rcv_mode_left = $urandom_range(50, 300);
      end else begin
        rcv_mode_left--;
      end
      if (hold_left != 0) begin
        hold_left--;
        nxt_stall = 1'b1;
      end else if (holds_done < 2 &&
                   n_sent >= (holds_done == 0 ? HOLD_MARK_A : HOLD_MARK_B)) begin
        hold_left = HOLD_LEN - 1;
        holds_done++;
        nxt_stall = 1'b1;
      end else if (rcv_gap != 0) begin
        rcv_gap--;
        nxt_stall = 1'b1;
      end else if (rcv_noisy && !calm && $urandom_range(0, 5) == 0) begin
        rcv_gap   = $urandom_range(0, 12);
        nxt_stall = 1'b1;
      end
      if (nxt_stall) n_held++;
    end
    out_stall <= nxt_stall;
  end

  // --------------------------------------------------------------------------
  // Monitor: each accepted result against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    remap_res_t want;
    if (rst_ni && out_valid && !out_stall) begin
      n_done <= n_done + 1;
      if (exp_remaps.size() == 0) begin
        flag_error($sformatf("unexpected result node=%0d addr=%h new=%b full=%b",
                             node_id, mapped_addr, was_new, table_full));
      end else begin
        want = exp_remaps.pop_front();
        if (node_id !== want.node)
          flag_error($sformatf("node_id %0d, expected %0d", node_id, want.node));
        if (mapped_addr !== want.addr)
          flag_error($sformatf("mapped_addr %h, expected %h", mapped_addr, want.addr));
        if (was_new !== want.is_new)
          flag_error($sformatf("was_new %b, expected %b", was_new, want.is_new));
        if (table_full !== want.full)
          flag_error($sformatf("table_full %b, expected %b", table_full, want.full));
        if (want.full) n_full_seen++;
        else if (want.is_new) n_new_seen++;
        else n_hit_seen++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  logic [fsnr_pkg::ADDR_W-1:0] addr_pool [$];  // addresses already requested

  task automatic push_req(input logic [fsnr_pkg::ADDR_W-1:0] ip);
    step_t s;
    s      = '0;
    s.kind = STEP_REQ;
    s.ip   = ip;
    req_backlog.push_back(s);
    addr_pool.push_back(ip);
    n_total++;
  endtask

  task automatic push_cfg(input logic [fsnr_pkg::CFG_IDX_W-1:0] idx,
                          input logic [fsnr_pkg::ADDR_W-1:0] data);
    step_t s;
    s      = '0;
    s.kind = STEP_CFG;
    s.idx  = idx;
    s.data = data;
    req_backlog.push_back(s);
  endtask

  task automatic push_drain();
    step_t s;
    s      = '0;
    s.kind = STEP_DRAIN;
    req_backlog.push_back(s);
  endtask

  // n requests, pct_new percent fresh addresses; some fresh ones are built to
  // land on the same hash slot as a known address (paired bit flips 10 apart)
  task automatic push_mix(input int unsigned n, input int unsigned pct_new);
    logic [fsnr_pkg::ADDR_W-1:0] ip;
    for (int unsigned i = 0; i < n; i++) begin
      if (addr_pool.size() == 0 || $urandom_range(0, 99) < pct_new) begin
        if (addr_pool.size() != 0 && $urandom_range(0, 9) == 0)
          ip = addr_pool[$urandom_range(0, addr_pool.size() - 1)]
               ^ (32'h0000_0401 << $urandom_range(0, 21));
        else
          ip = $urandom;
      end else begin
        ip = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
      end
      push_req(ip);
    end
  endtask

  initial begin : run
    logic [fsnr_pkg::ADDR_W-1:0] directed_ips [16];
    directed_ips = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0401,
                     32'h4010_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001,
                     32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF, 32'h0000_0401,
                     32'h4010_0000, 32'h1234_5678, 32'hEDCB_A987, 32'h0000_0000};

    // directed: field extremes, repeats, keys colliding on one hash slot,
    // all under the reset register values
    foreach (directed_ips[i]) push_req(directed_ips[i]);

    // all-ones base and stride: every sum wraps
    push_cfg(fsnr_pkg::REG_BASE_IP, 32'hFFFF_FFFF);
    push_cfg(fsnr_pkg::REG_NODE_STRIDE, 32'hFFFF_FFFF);
    push_mix(270, 50);

    // zero base and stride, then writes to the spare indexes (ignored)
    push_cfg(fsnr_pkg::REG_BASE_IP, 32'h0000_0000);
    push_cfg(fsnr_pkg::REG_NODE_STRIDE, 32'h0000_0000);
    push_cfg(REG_SPARE_2, $urandom);
    push_cfg(REG_SPARE_3, $urandom);
    push_mix(135, 50);
    push_drain();
    push_mix(135, 50);

    push_cfg(fsnr_pkg::REG_BASE_IP, $urandom);
    push_cfg(fsnr_pkg::REG_NODE_STRIDE, $urandom);
    push_mix(270, 50);

    push_cfg(fsnr_pkg::REG_BASE_IP, 32'hFFFF_0000);
    push_cfg(fsnr_pkg::REG_NODE_STRIDE, 32'h0000_0001);
    push_mix(270, 50);

    // fill the map past its depth, then mostly hits with some full misses
    push_cfg(fsnr_pkg::REG_BASE_IP, $urandom);
    push_cfg(fsnr_pkg::REG_NODE_STRIDE, $urandom);
    push_mix(560, 92);
    push_mix(300, 10);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (req_backlog.size() != 0 || in_valid || n_done != n_sent) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (exp_remaps.size() != 0)
      flag_error($sformatf("%0d results never arrived", exp_remaps.size()));

    $display("Run covered %0d requests: %0d first-seen, %0d repeats, %0d table-full misses",
             n_sent, n_new_seen, n_hit_seen, n_full_seen);
    $display("%0d register writes, %0d receiver stall cycles, %0d mismatches",
             n_cfg_writes, n_held, n_errors);
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run (every request a full-map miss)
  initial begin : watchdog
    #200_000_000;
    $display("Timeout: %0d of %0d requests sent, %0d results", n_sent, n_total, n_done);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/fsnr_pkg.sv
hdl/fsnr_ctrl.sv
hdl/fsnr_dp.sv
hdl/first_seen_ip_to_node_remap.sv
hdl/fsnr_checker.sv
test/tb_first_seen_ip_to_node_remap.sv
